[rtl/vrbc_pkg.sv]
`default_nettype none

package vrbc_pkg;

  // Fixed field widths of the block's ports and of the valid-cell count.
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned EXT_W      = 11;
  localparam int unsigned VAL_W      = 8;
  localparam int unsigned BOX_W      = 11;
  localparam int unsigned CNT_W      = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // The volume product: two box widths, then a third.
  localparam int unsigned PAIR_W = 2 * BOX_W;
  localparam int unsigned VOL_W  = 3 * BOX_W;

  localparam int unsigned DEF_MAX_EXTENT = 1024;

  // Register values after reset.
  localparam logic [AXIS_W-1:0] AXIS_RST   = 2'd3;
  localparam logic [EXT_W-1:0]  EXTENT_RST = 11'd1;
  localparam logic [VAL_W-1:0]  KEEP_RST   = 8'd0;

  // Box corner reported when no cell of the grid is valid.
  localparam logic [BOX_W-1:0] BOX_NONE = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_COUNT = 3'd0,
    REG_EXTENT_X   = 3'd1,
    REG_EXTENT_Y   = 3'd2,
    REG_EXTENT_Z   = 3'd3,
    REG_KEEP_LOW   = 3'd4,
    REG_KEEP_HIGH  = 3'd5
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;   // a cell request is taken this cycle
    logic snap;   // capture the finished grid, clear the accumulators
    logic mul1;   // first volume product stage
    logic mul2;   // second volume product stage
    logic load;   // load the result register
  } vrbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_cell;  // the cell at the current position closes the grid
  } vrbc_sts_t;

endpackage

`default_nettype wire

[rtl/vrbc_ctrl.sv]
`default_nettype none

module vrbc_ctrl
  import vrbc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  input  wire vrbc_sts_t sts_i,
  output vrbc_cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    ST_RUN  = 5'b00001,
    ST_SNAP = 5'b00010,
    ST_MUL1 = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_RUN: begin
        cmd_o.step = in_valid_i;
        if (in_valid_i && sts_i.last_cell) begin
          state_d = ST_SNAP;
        end
      end
      ST_SNAP: begin
        cmd_o.snap = 1'b1;
        state_d    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_RUN);
  assign out_valid_o = out_valid_q;

  // The request that closes a grid is followed by a stalled input.
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && sts_i.last_cell) |=> in_stall_o)
    else $error("input not stalled after the last cell of a grid");

  // A new result only appears out of the result state.
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result valid raised outside the result state");

endmodule

`default_nettype wire

[rtl/vrbc_datapath.sv]
`default_nettype none

module vrbc_datapath
  import vrbc_pkg::*;
#(
  parameter int unsigned MAX_EXTENT = DEF_MAX_EXTENT
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic [VAL_W-1:0]       ghost_value_i,
  input  wire vrbc_cmd_t              cmd_i,
  output vrbc_sts_t                   sts_o,
  output logic                        strip_ok_o,
  output logic                        strip_needed_o,
  output logic signed [BOX_W-1:0]     box_min_x_o,
  output logic signed [BOX_W-1:0]     box_max_x_o,
  output logic signed [BOX_W-1:0]     box_min_y_o,
  output logic signed [BOX_W-1:0]     box_max_y_o,
  output logic signed [BOX_W-1:0]     box_min_z_o,
  output logic signed [BOX_W-1:0]     box_max_z_o
);

  localparam int unsigned CW = (MAX_EXTENT > 1) ? $clog2(MAX_EXTENT) : 1;

  // Configuration registers.
  logic [AXIS_W-1:0] axis_count_q;
  logic [EXT_W-1:0]  extent_q [3];
  logic [VAL_W-1:0]  keep_low_q, keep_high_q;

  // Grid walk and accumulators.
  logic [CW-1:0]     pos_q [3];
  logic [CW-1:0]     pos_d [3];
  logic [CW-1:0]     low_q [3];
  logic [CW-1:0]     low_d [3];
  logic [CW-1:0]     high_q [3];
  logic [CW-1:0]     high_d [3];
  logic              any_q, any_d;
  logic [CNT_W-1:0]  total_q, total_d;

  // Snapshot of a finished grid and the volume product.
  logic [BOX_W-1:0]  wid_q [3];
  logic [BOX_W-1:0]  box_lo_q [3];
  logic [BOX_W-1:0]  box_hi_q [3];
  logic              mism_q;
  logic [CNT_W-1:0]  snap_total_q;
  logic [PAIR_W-1:0] pair_q;
  logic [VOL_W-1:0]  vol_q;

  logic              can_q, should_q;
  logic [BOX_W-1:0]  out_lo_q [3];
  logic [BOX_W-1:0]  out_hi_q [3];

  logic [AXIS_W-1:0] axes;
  logic              act [3];
  logic [EXT_W-1:0]  ext_eff [3];
  logic [CW-1:0]     coord [3];
  logic              last [3];
  logic              hit;
  logic [BOX_W-1:0]  wid_d [3];
  logic              mism_d;
  logic              can_d;

  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] e);
    logic [EXT_W-1:0] r;
    if (e == '0) begin
      r = EXT_W'(1);
    end else if (32'(e) > 32'(MAX_EXTENT)) begin
      r = EXT_W'(MAX_EXTENT);
    end else begin
      r = e;
    end
    return r;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_count_q <= AXIS_RST;
      extent_q[0]  <= EXTENT_RST;
      extent_q[1]  <= EXTENT_RST;
      extent_q[2]  <= EXTENT_RST;
      keep_low_q   <= KEEP_RST;
      keep_high_q  <= KEEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_AXIS_COUNT: axis_count_q <= cfg_data_i[AXIS_W-1:0];
        REG_EXTENT_X:   extent_q[0]  <= cfg_data_i;
        REG_EXTENT_Y:   extent_q[1]  <= cfg_data_i;
        REG_EXTENT_Z:   extent_q[2]  <= cfg_data_i;
        REG_KEEP_LOW:   keep_low_q   <= cfg_data_i[VAL_W-1:0];
        REG_KEEP_HIGH:  keep_high_q  <= cfg_data_i[VAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Active axes, effective extents and the current cell position.
  assign axes   = (axis_count_q == '0) ? AXIS_W'(1) : axis_count_q;
  assign act[0] = 1'b1;
  assign act[1] = (axes >= AXIS_W'(2));
  assign act[2] = (axes == AXIS_W'(3));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext_eff[i] = act[i] ? clamp_extent(extent_q[i]) : EXT_W'(1);
      coord[i]   = act[i] ? pos_q[i] : '0;
      last[i]    = (32'(coord[i]) + 32'd1) >= 32'(ext_eff[i]);
    end
  end

  assign hit             = (ghost_value_i >= keep_low_q) && (ghost_value_i <= keep_high_q);
  assign sts_o.last_cell = last[0] && last[1] && last[2];

  // Accumulator and position update.
  always_comb begin
    pos_d   = pos_q;
    low_d   = low_q;
    high_d  = high_q;
    any_d   = any_q;
    total_d = total_q;
    if (cmd_i.step) begin
      if (hit) begin
        for (int i = 0; i < 3; i++) begin
          if (!any_q || (coord[i] < low_q[i])) begin
            low_d[i] = coord[i];
          end
          if (!any_q || (coord[i] > high_q[i])) begin
            high_d[i] = coord[i];
          end
        end
        any_d   = 1'b1;
        total_d = total_q + CNT_W'(1);
      end
      if (sts_o.last_cell) begin
        pos_d[0] = '0;
        pos_d[1] = '0;
        pos_d[2] = '0;
      end else if (!last[0]) begin
        pos_d[0] = coord[0] + CW'(1);
      end else begin
        pos_d[0] = '0;
        if (!last[1]) begin
          pos_d[1] = coord[1] + CW'(1);
        end else begin
          pos_d[1] = '0;
          pos_d[2] = coord[2] + CW'(1);
        end
      end
    end else if (cmd_i.snap) begin
      any_d   = 1'b0;
      total_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      any_q    <= 1'b0;
      total_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      any_q   <= any_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
  end

  // Box widths of the finished grid; an empty grid has width one.
  always_comb begin
    mism_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (act[i] && any_q) begin
        wid_d[i] = BOX_W'(32'(high_q[i]) - 32'(low_q[i]) + 32'd1);
      end else begin
        wid_d[i] = BOX_W'(1);
      end
      if (act[i] && (ext_eff[i] != wid_d[i])) begin
        mism_d = 1'b1;
      end
    end
  end

  assign can_d = (snap_total_q == '0) || (VOL_W'(snap_total_q) == vol_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      for (int i = 0; i < 3; i++) begin
        wid_q[i] <= wid_d[i];
        if (!act[i]) begin
          box_lo_q[i] <= '0;
          box_hi_q[i] <= '0;
        end else if (!any_q) begin
          box_lo_q[i] <= BOX_NONE;
          box_hi_q[i] <= BOX_NONE;
        end else begin
          box_lo_q[i] <= BOX_W'(32'(low_q[i]));
          box_hi_q[i] <= BOX_W'(32'(high_q[i]));
        end
      end
      mism_q       <= mism_d;
      snap_total_q <= total_q;
    end
    if (cmd_i.mul1) begin
      pair_q <= PAIR_W'(wid_q[0]) * PAIR_W'(wid_q[1]);
    end
    if (cmd_i.mul2) begin
      vol_q <= VOL_W'(pair_q) * VOL_W'(wid_q[2]);
    end
    if (cmd_i.load) begin
      can_q    <= can_d;
      should_q <= !can_d || mism_q;
      out_lo_q <= box_lo_q;
      out_hi_q <= box_hi_q;
    end
  end

  assign strip_ok_o     = can_q;
  assign strip_needed_o = should_q;
  assign box_min_x_o    = out_lo_q[0];
  assign box_max_x_o    = out_hi_q[0];
  assign box_min_y_o    = out_lo_q[1];
  assign box_max_y_o    = out_hi_q[1];
  assign box_min_z_o    = out_lo_q[2];
  assign box_max_z_o    = out_hi_q[2];

  // The box of the valid cells never turns inside out.
  a_corner_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_q |-> ((low_q[0] <= high_q[0]) && (low_q[1] <= high_q[1])
               && (low_q[2] <= high_q[2])))
    else $error("box corners out of order");

  // A grid without counted cells can always be stripped.
  a_empty_can_strip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && (snap_total_q == '0)) |=> can_q)
    else $error("empty count gave strip_ok low");

  // The accumulators start empty after a grid is captured.
  a_clear_after_snap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.snap |=> (!any_q && (total_q == '0)))
    else $error("accumulators not cleared after capture");

endmodule

`default_nettype wire

[rtl/valid_region_box_check_unit.sv]
// Valid-region box check. Cell ghost markers arrive one request per cell in
// raster order with x fastest, over a grid of one to three axes set by the
// axis_count and extent registers. A cell is valid when keep_low <= marker
// <= keep_high. The unit tracks the cell position with counters, keeps the
// bounding box and the count of valid cells, and after the last cell of the
// grid delivers one result request: strip_ok is high when the valid count
// fills the box volume or is zero, strip_needed is high when strip_ok is
// low or a box width differs from an active extent, and the box corners
// read -1 when no cell was valid and 0 on unused axes. Cells are taken back
// to back while the input is not stalled. After the last cell of a grid the
// input stalls through capture, two registered multiplier stages for the box
// volume and result, and longer while the previous result is stalled in the
// output register, which holds a finished result while the next grid streams
// in. Registers are to be written only while the unit is idle, which the unit
// does not enforce; a write takes effect once the register has captured it.

`default_nettype none

module valid_region_box_check_unit
  import vrbc_pkg::*;
#(
  parameter int unsigned MAX_EXTENT = DEF_MAX_EXTENT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,

  // Register write port.
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,

  // Cell request channel.
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [VAL_W-1:0]      ghost_value_i,

  // Result request channel.
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       strip_ok_o,
  output logic                       strip_needed_o,
  output logic signed [BOX_W-1:0]    box_min_x_o,
  output logic signed [BOX_W-1:0]    box_max_x_o,
  output logic signed [BOX_W-1:0]    box_min_y_o,
  output logic signed [BOX_W-1:0]    box_max_y_o,
  output logic signed [BOX_W-1:0]    box_min_z_o,
  output logic signed [BOX_W-1:0]    box_max_z_o
);

  vrbc_cmd_t cmd;
  vrbc_sts_t sts;

  // The controller sequences the grid walk and the end-of-grid steps.
  vrbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the registers, the counters, the box and the volume
  // multiplier.
  vrbc_datapath #(
    .MAX_EXTENT (MAX_EXTENT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .ghost_value_i  (ghost_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .strip_ok_o     (strip_ok_o),
    .strip_needed_o (strip_needed_o),
    .box_min_x_o    (box_min_x_o),
    .box_max_x_o    (box_max_x_o),
    .box_min_y_o    (box_min_y_o),
    .box_max_y_o    (box_max_y_o),
    .box_min_z_o    (box_min_z_o),
    .box_max_z_o    (box_max_z_o)
  );

endmodule

`default_nettype wire
